// ===== rtl/mbfd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbfd_pkg
// Shared types, codes and helper functions for the basic-mode frame deframer.
// ---------------------------------------------------------------------------
package mbfd_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'hF9;
  localparam logic [7:0] FCS_INIT    = 8'hFF;
  localparam logic [7:0] FCS_RESIDUE = 8'hCF;
  localparam logic [7:0] FCS_POLY    = 8'hE0;
  localparam logic [7:0] PF_MASK     = 8'hEF;

  // Control byte values with the poll/final bit cleared
  localparam logic [7:0] CTRL_UIH  = 8'd239;
  localparam logic [7:0] CTRL_UI   = 8'd3;
  localparam logic [7:0] CTRL_SABM = 8'd47;
  localparam logic [7:0] CTRL_UA   = 8'd99;
  localparam logic [7:0] CTRL_DM   = 8'd15;
  localparam logic [7:0] CTRL_DISC = 8'd67;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_ADDR  = 4'd1,
    PH_CTRL  = 4'd2,
    PH_LEN1  = 4'd3,
    PH_LEN2  = 4'd4,
    PH_DATA  = 4'd5,
    PH_FCS   = 4'd6,
    PH_CLOSE = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    FT_UIH   = 3'd0,
    FT_UI    = 3'd1,
    FT_SABM  = 3'd2,
    FT_UA    = 3'd3,
    FT_DM    = 3'd4,
    FT_DISC  = 3'd5,
    FT_OTHER = 3'd6
  } frame_type_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_FCS_BAD  = 2'd1,
    ST_NO_CLOSE = 2'd2
  } status_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       item_kind;
    logic [7:0]  data_byte;
    logic [5:0]  channel;
    logic [7:0]  control_byte;
    frame_type_e frame_type;
    logic        poll_final;
    logic [14:0] payload_length;
    status_e     status;
    logic        last;
  } res_t;

  // Reflected CRC-8 step over one byte, LSB first
  function automatic logic [7:0] fcs_update(logic [7:0] acc, logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic frame_type_e type_code(logic [7:0] ctrl);
    frame_type_e t;
    case (ctrl & PF_MASK)
      CTRL_UIH:  t = FT_UIH;
      CTRL_UI:   t = FT_UI;
      CTRL_SABM: t = FT_SABM;
      CTRL_UA:   t = FT_UA;
      CTRL_DM:   t = FT_DM;
      CTRL_DISC: t = FT_DISC;
      default:   t = FT_OTHER;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/mbfd_fsm.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbfd_fsm
// Frame phase tracker: header capture, FCS accumulation and result build.
// ---------------------------------------------------------------------------
module mbfd_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output mbfd_pkg::res_t    res_o
);

  mbfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  fcs_q, fcs_d;
  logic [5:0]  chan_q, chan_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [14:0] len_q, len_d;
  logic [14:0] cnt_q, cnt_d;
  logic [14:0] cnt_inc;
  logic [7:0]  fcs_next;
  logic        emit;
  mbfd_pkg::kind_e   kind;
  mbfd_pkg::status_e stat;

  assign fcs_next = mbfd_pkg::fcs_update(fcs_q, rx_byte_i);
  assign cnt_inc  = cnt_q + 15'd1;

  // Next state
  always_comb begin
    phase_d = phase_q;
    fcs_d   = fcs_q;
    chan_d  = chan_q;
    ctrl_d  = ctrl_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    case (phase_q)
      mbfd_pkg::PH_ADDR: begin
        if (rx_byte_i != mbfd_pkg::FLAG_BYTE) begin
          chan_d  = rx_byte_i[7:2];
          fcs_d   = mbfd_pkg::fcs_update(mbfd_pkg::FCS_INIT, rx_byte_i);
          phase_d = mbfd_pkg::PH_CTRL;
        end
      end
      mbfd_pkg::PH_CTRL: begin
        ctrl_d  = rx_byte_i;
        fcs_d   = fcs_next;
        phase_d = mbfd_pkg::PH_LEN1;
      end
      mbfd_pkg::PH_LEN1: begin
        len_d = {8'd0, rx_byte_i[7:1]};
        fcs_d = fcs_next;
        cnt_d = '0;
        if (!rx_byte_i[0]) begin
          phase_d = mbfd_pkg::PH_LEN2;
        end else if (rx_byte_i[7:1] == 7'd0) begin
          phase_d = mbfd_pkg::PH_FCS;
        end else begin
          phase_d = mbfd_pkg::PH_DATA;
        end
      end
      mbfd_pkg::PH_LEN2: begin
        len_d   = len_q + {rx_byte_i, 7'd0};
        fcs_d   = fcs_next;
        cnt_d   = '0;
        phase_d = ((len_q + {rx_byte_i, 7'd0}) == 15'd0) ? mbfd_pkg::PH_FCS
                                                          : mbfd_pkg::PH_DATA;
      end
      mbfd_pkg::PH_DATA: begin
        // only UI frames cover the payload
        if ((ctrl_q & mbfd_pkg::PF_MASK) == mbfd_pkg::CTRL_UI) begin
          fcs_d = fcs_next;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = mbfd_pkg::PH_FCS;
        end
      end
      mbfd_pkg::PH_FCS: begin
        phase_d = (fcs_next != mbfd_pkg::FCS_RESIDUE) ? mbfd_pkg::PH_HUNT
                                                       : mbfd_pkg::PH_CLOSE;
      end
      mbfd_pkg::PH_CLOSE: begin
        // a good closing flag doubles as the next opening flag
        phase_d = (rx_byte_i != mbfd_pkg::FLAG_BYTE) ? mbfd_pkg::PH_HUNT
                                                      : mbfd_pkg::PH_ADDR;
      end
      default: begin
        phase_d = (rx_byte_i == mbfd_pkg::FLAG_BYTE) ? mbfd_pkg::PH_ADDR
                                                      : mbfd_pkg::PH_HUNT;
      end
    endcase
  end

  // Outputs
  always_comb begin
    emit = 1'b0;
    kind = mbfd_pkg::KIND_DATA;
    stat = mbfd_pkg::ST_GOOD;
    case (phase_q)
      mbfd_pkg::PH_DATA: begin
        emit = 1'b1;
      end
      mbfd_pkg::PH_FCS: begin
        if (fcs_next != mbfd_pkg::FCS_RESIDUE) begin
          emit = 1'b1;
          kind = mbfd_pkg::KIND_END;
          stat = mbfd_pkg::ST_FCS_BAD;
        end
      end
      mbfd_pkg::PH_CLOSE: begin
        emit = 1'b1;
        kind = mbfd_pkg::KIND_END;
        stat = (rx_byte_i != mbfd_pkg::FLAG_BYTE) ? mbfd_pkg::ST_NO_CLOSE
                                                   : mbfd_pkg::ST_GOOD;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign res_valid_o          = beat_i & emit;
  assign res_o.item_kind      = kind;
  assign res_o.data_byte      = (kind == mbfd_pkg::KIND_DATA) ? rx_byte_i : 8'd0;
  assign res_o.channel        = chan_q;
  assign res_o.control_byte   = ctrl_q;
  assign res_o.frame_type     = mbfd_pkg::type_code(ctrl_q);
  assign res_o.poll_final     = ctrl_q[4];
  assign res_o.payload_length = len_q;
  assign res_o.status         = stat;
  assign res_o.last           = (kind == mbfd_pkg::KIND_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mbfd_pkg::PH_HUNT;
      fcs_q   <= mbfd_pkg::FCS_INIT;
      chan_q  <= '0;
      ctrl_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      fcs_q   <= fcs_d;
      chan_q  <= chan_d;
      ctrl_q  <= ctrl_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/mbfd_out_buf.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbfd_out_buf
// Two-entry result buffer: a two-slot ring with read and write pointers.
// ---------------------------------------------------------------------------
module mbfd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbfd_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output mbfd_pkg::res_t data_o
);

  mbfd_pkg::res_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/mux_basic_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mux_basic_frame_deframer_core
// Recovers basic-mode multiplexer frames from a serial byte stream.
//
//   channel  dir  handshake           beat
//   rx       in   rx_valid/rx_stall   one received byte
//   res      out  res_valid/res_stall payload byte or frame end report
//
// One byte per cycle while rx is not stalled; each byte updates the phase
// tracker in the cycle it is taken and its result (if any) is registered in
// the output buffer. The two-entry buffer decouples the sides; rx stalls
// whenever both entries are held, even in a cycle where the output takes one.
// Reset leaves the block hunting for a flag with an empty output buffer.
// ---------------------------------------------------------------------------
module mux_basic_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [5:0]  channel_o,
  output logic [7:0]  control_byte_o,
  output logic [2:0]  frame_type_o,
  output logic        poll_final_o,
  output logic [14:0] payload_length_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic           beat;
  logic           full;
  logic           push;
  mbfd_pkg::res_t push_data;
  mbfd_pkg::res_t out_data;

  assign rx_stall_o = full;
  assign beat       = rx_valid_i & ~full;

  mbfd_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (push),
    .res_o       (push_data)
  );

  mbfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (res_valid_o),
    .stall_i     (res_stall_i),
    .data_o      (out_data)
  );

  assign item_kind_o      = out_data.item_kind;
  assign data_byte_o      = out_data.data_byte;
  assign channel_o        = out_data.channel;
  assign control_byte_o   = out_data.control_byte;
  assign frame_type_o     = out_data.frame_type;
  assign poll_final_o     = out_data.poll_final;
  assign payload_length_o = out_data.payload_length;
  assign status_o         = out_data.status;
  assign last_o           = out_data.last;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives serial bytes into the basic-mode frame deframer and checks every
// payload beat and frame end report against an in-bench deframer. The line
// carries directed corner frames, then random frames (mostly well formed,
// some with a bad FCS or no closing flag, some noise), then one long frame
// with a two-byte length field. Both sides idle at random; the receiver holds
// off once for a long stretch so that the block fills up.
// ---------------------------------------------------------------------------
module testbench;
  import mbfd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_AFTER  = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum {FRAME_OK, FRAME_BAD_FCS, FRAME_NO_CLOSE} frame_fault_e;

  typedef struct {
    logic [7:0]  value;
    int unsigned gap;
  } line_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        item_kind_o;
  logic [7:0]  data_byte_o;
  logic [5:0]  channel_o;
  logic [7:0]  control_byte_o;
  logic [2:0]  frame_type_o;
  logic        poll_final_o;
  logic [14:0] payload_length_o;
  logic [1:0]  status_o;
  logic        last_o;

  mux_basic_frame_deframer_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_o       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_stall_i      (res_stall_i),
    .item_kind_o      (item_kind_o),
    .data_byte_o      (data_byte_o),
    .channel_o        (channel_o),
    .control_byte_o   (control_byte_o),
    .frame_type_o     (frame_type_o),
    .poll_final_o     (poll_final_o),
    .payload_length_o (payload_length_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  // line bytes waiting to be driven, and deframed beats waiting to come out
  line_beat_t line_bytes_q[$];
  res_t       deframed_q[$];

  // in-bench deframer state
  phase_e      trk_phase = PH_HUNT;
  logic [7:0]  trk_fcs = FCS_INIT;
  logic [5:0]  trk_chan = '0;
  logic [7:0]  trk_ctrl = '0;
  logic [14:0] trk_len = '0;
  logic [14:0] trk_seen = '0;

  // stimulus build state
  int unsigned send_mode = 0;
  int unsigned mode_items = 0;
  int unsigned frame_bytes = 0;
  bit          line_open = 1'b0;

  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_taken = 0;
  int unsigned payload_seen = 0;
  int unsigned good_frames = 0;
  int unsigned fcs_failures = 0;
  int unsigned close_failures = 0;

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[0] ? ({1'b0, c[7:1]} ^ FCS_POLY) : {1'b0, c[7:1]};
    return c;
  endfunction

  function automatic frame_type_e ctrl_class(input logic [7:0] ctrl);
    logic [7:0] m;
    m = ctrl & PF_MASK;
    if (m == CTRL_UIH)  return FT_UIH;
    if (m == CTRL_UI)   return FT_UI;
    if (m == CTRL_SABM) return FT_SABM;
    if (m == CTRL_UA)   return FT_UA;
    if (m == CTRL_DM)   return FT_DM;
    if (m == CTRL_DISC) return FT_DISC;
    return FT_OTHER;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] non_flag_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == FLAG_BYTE) v = 8'h00;
    return v;
  endfunction

  // Advances the in-bench deframer by one line byte and queues any beat it yields
  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    bit   yields;
    yields = 1'b0;
    r.item_kind = KIND_DATA;
    r.data_byte = 8'h00;
    r.status = ST_GOOD;
    case (trk_phase)
      PH_ADDR: begin
        if (b != FLAG_BYTE) begin
          trk_chan = b[7:2];
          trk_fcs = crc8_step(FCS_INIT, b);
          trk_phase = PH_CTRL;
        end
      end
      PH_CTRL: begin
        trk_ctrl = b;
        trk_fcs = crc8_step(trk_fcs, b);
        trk_phase = PH_LEN1;
      end
      PH_LEN1: begin
        trk_len = {8'h00, b[7:1]};
        trk_fcs = crc8_step(trk_fcs, b);
        if (b[0]) begin
          trk_seen = '0;
          trk_phase = (trk_len == 0) ? PH_FCS : PH_DATA;
        end else begin
          trk_phase = PH_LEN2;
        end
      end
      PH_LEN2: begin
        trk_len = trk_len + {b, 7'd0};
        trk_fcs = crc8_step(trk_fcs, b);
        trk_seen = '0;
        trk_phase = (trk_len == 0) ? PH_FCS : PH_DATA;
      end
      PH_DATA: begin
        // payload is covered by the FCS on UI frames only
        if ((trk_ctrl & PF_MASK) == CTRL_UI) trk_fcs = crc8_step(trk_fcs, b);
        trk_seen = trk_seen + 1'b1;
        if (trk_seen >= trk_len) trk_phase = PH_FCS;
        r.data_byte = b;
        yields = 1'b1;
      end
      PH_FCS: begin
        if (crc8_step(trk_fcs, b) != FCS_RESIDUE) begin
          trk_phase = PH_HUNT;
          r.item_kind = KIND_END;
          r.status = ST_FCS_BAD;
          yields = 1'b1;
        end else begin
          trk_phase = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        r.item_kind = KIND_END;
        yields = 1'b1;
        if (b != FLAG_BYTE) begin
          trk_phase = PH_HUNT;
          r.status = ST_NO_CLOSE;
        end else begin
          trk_phase = PH_ADDR;
        end
      end
      default: trk_phase = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
    endcase
    if (yields) begin
      r.channel = trk_chan;
      r.control_byte = trk_ctrl;
      r.frame_type = ctrl_class(trk_ctrl);
      r.poll_final = trk_ctrl[4];
      r.payload_length = trk_len;
      r.last = (r.item_kind == KIND_END);
      deframed_q.push_back(r);
    end
  endtask

  task automatic send(input logic [7:0] b);
    line_beat_t beat;
    if (mode_items == 0) begin
      send_mode = $urandom_range(0, 3);
      mode_items = $urandom_range(20, 120);
    end else begin
      mode_items--;
    end
    beat.value = b;
    beat.gap = (send_mode != 0 && $urandom_range(0, 99) < send_mode * 20) ? draw_gap() : 0;
    line_bytes_q.push_back(beat);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                            input int unsigned len, input bit two_byte,
                            input frame_fault_e fault);
    logic [7:0] acc;
    logic [7:0] hdr;
    logic [7:0] pb;
    logic [7:0] fcs_byte;
    acc = crc8_step(FCS_INIT, addr);
    send(addr);
    acc = crc8_step(acc, ctrl);
    send(ctrl);
    hdr = {len[6:0], ~two_byte};
    acc = crc8_step(acc, hdr);
    send(hdr);
    if (two_byte) begin
      acc = crc8_step(acc, len[14:7]);
      send(len[14:7]);
    end
    for (int i = 0; i < len; i++) begin
      pb = ($urandom_range(0, 15) == 0) ? FLAG_BYTE : 8'($urandom_range(0, 255));
      if ((ctrl & PF_MASK) == CTRL_UI) acc = crc8_step(acc, pb);
      send(pb);
    end
    fcs_byte = 8'h00;
    for (int v = 0; v < 256; v++) begin
      if (crc8_step(acc, 8'(v)) == FCS_RESIDUE) fcs_byte = 8'(v);
    end
    // a single flipped bit always breaks the residue
    if (fault == FRAME_BAD_FCS) fcs_byte = fcs_byte ^ (8'h01 << $urandom_range(0, 7));
    send(fcs_byte);
    if (fault == FRAME_OK) send(FLAG_BYTE);
    else if (fault == FRAME_NO_CLOSE) send(non_flag_byte());
    line_open = (fault == FRAME_OK);
    frame_bytes += len + 5 + two_byte;
  endtask

  function automatic logic [7:0] pick_ctrl();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CTRL_UIH;
      1: c = CTRL_UI;
      2: c = CTRL_SABM;
      3: c = CTRL_UA;
      4: c = CTRL_DM;
      5: c = CTRL_DISC;
      default: c = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 1) == 1) c[4] = ~c[4];
    return c;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [14:0] got,
                             input logic [14:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // sender: holds each byte until taken, then idles for the byte's gap
  int unsigned gap_left = 0;
  line_beat_t  next_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && !rx_stall_o) begin
        deframe_byte(rx_byte_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (!rx_valid_i || !rx_stall_o) begin
        if (gap_left != 0) begin
          rx_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (line_bytes_q.size() != 0) begin
          next_beat = line_bytes_q.pop_front();
          rx_valid_i <= 1'b1;
          rx_byte_i <= next_beat.value;
          gap_left <= next_beat.gap;
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls: random bursts by mode, plus one long hold-off
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        res_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        res_stall_i <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else if (stall_left != 0) begin
        res_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        res_stall_i <= 1'b0;
        if (stall_mode != 0 && $urandom_range(0, 99) < stall_mode * 15)
          stall_left <= draw_gap();
      end
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(50, 300);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
    end
  end

  res_t want;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      results_taken <= results_taken + 1;
      if (deframed_q.size() == 0) begin
        flag_mismatch("beat out with nothing expected");
      end else begin
        want = deframed_q.pop_front();
        check_field("item_kind", 15'(item_kind_o), 15'(want.item_kind));
        check_field("data_byte", 15'(data_byte_o), 15'(want.data_byte));
        check_field("channel", 15'(channel_o), 15'(want.channel));
        check_field("control_byte", 15'(control_byte_o), 15'(want.control_byte));
        check_field("frame_type", 15'(frame_type_o), 15'(want.frame_type));
        check_field("poll_final", 15'(poll_final_o), 15'(want.poll_final));
        check_field("payload_length", payload_length_o, want.payload_length);
        check_field("status", 15'(status_o), 15'(want.status));
        check_field("last", 15'(last_o), 15'(want.last));
        if (want.item_kind == KIND_DATA) payload_seen <= payload_seen + 1;
        else if (want.status == ST_GOOD) good_frames <= good_frames + 1;
        else if (want.status == ST_FCS_BAD) fcs_failures <= fcs_failures + 1;
        else close_failures <= close_failures + 1;
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // directed: noise while hunting, repeated flags, zero length, UI payload,
    // bad FCS, two-byte zero length with the closing flag missing
    send(8'h00);
    send(8'hFF);
    repeat (3) send(FLAG_BYTE);
    line_open = 1'b1;
    send_frame(8'hFC, CTRL_SABM | 8'h10, 0, 1'b0, FRAME_OK);
    send_frame(8'h03, CTRL_UI | 8'h10, 2, 1'b0, FRAME_OK);
    send_frame(8'h87, CTRL_DM, 0, 1'b0, FRAME_BAD_FCS);
    send(FLAG_BYTE);
    send_frame(8'h42, CTRL_UA, 0, 1'b1, FRAME_NO_CLOSE);

    while (frame_bytes < 1520) begin
      if (!line_open && $urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4)) send(non_flag_byte());
      end
      if (!line_open || $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send(FLAG_BYTE);
        line_open = 1'b1;
      end
      begin
        int unsigned r;
        int unsigned len;
        bit          two_byte;
        frame_fault_e fault;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          len = $urandom_range(0, 8);
          two_byte = 1'b0;
        end else if (r < 80) begin
          len = $urandom_range(0, 8);
          two_byte = 1'b1;
        end else if (r < 95) begin
          len = $urandom_range(0, 127);
          two_byte = 1'b0;
        end else begin
          len = $urandom_range(128, 300);
          two_byte = 1'b1;
        end
        r = $urandom_range(0, 99);
        fault = (r < 80) ? FRAME_OK : (r < 92) ? FRAME_BAD_FCS : FRAME_NO_CLOSE;
        send_frame(non_flag_byte(), pick_ctrl(), len, two_byte, fault);
      end
    end

    // long frame: full low length bits plus a high length byte
    if (!line_open) send(FLAG_BYTE);
    send_frame(8'hFD, CTRL_UIH, 383, 1'b1, FRAME_OK);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (line_bytes_q.size() != 0 || rx_valid_i || deframed_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d line bytes taken, %0d payload beats checked", bytes_taken, payload_seen);
    $display("frame ends: %0d good, %0d bad FCS, %0d without closing flag",
             good_frames, fcs_failures, close_failures);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbfd_pkg.sv
rtl/mbfd_fsm.sv
rtl/mbfd_out_buf.sv
rtl/mux_basic_frame_deframer_core.sv
tb/testbench.sv
